>>> design/ebcp_pkg.sv
// ----------------------------------------------------------------------------
// ebcp_pkg
// Types and constants shared by the backup container parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ebcp_pkg;

  localparam int unsigned NONCE_BYTES = 12;
  localparam logic [63:0] MAX_CIPHER_BYTES = 64'd33554432;
  localparam logic [25:0] MIN_TOTAL = 26'd22;
  localparam logic [5:0] SECRET_LEN = 6'd32;
  localparam logic [5:0] CHILD_LEN = 6'd4;
  localparam logic [25:0] SEEN_MAX = 26'h3FF_FFFF;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_VERSION   = 2'd1,
    REG_ALGORITHM = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_VERSION  = 3'd1,
    KIND_PATH_LEN = 3'd2,
    KIND_CHILD    = 3'd3,
    KIND_SECRET   = 3'd4,
    KIND_ALGO     = 3'd5,
    KIND_NONCE    = 3'd6,
    KIND_CIPHER   = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    ST_NOT_FINAL  = 4'd0,
    ST_OK         = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_TRUNCATED  = 4'd4,
    ST_EMPTY_PATH = 4'd5,
    ST_NO_SECRETS = 4'd6,
    ST_ALGORITHM  = 4'd7,
    ST_BAD_LENGTH = 4'd8,
    ST_TOO_SHORT  = 4'd9
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [47:0] magic_word;
    logic [7:0]  format_version;
    logic [7:0]  algorithm_id;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/ebcp_if.sv
// ----------------------------------------------------------------------------
// ebcp_if
// Valid/ready channels for container bytes in and decoded elements out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ebcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [31:0] item_value;
  logic [7:0]  group_number;
  logic [24:0] element_number;
  logic [3:0]  end_status;

  modport source (
    output valid, output item_kind, output item_value, output group_number,
    output element_number, output end_status, input ready
  );
  modport sink (
    input valid, input item_kind, input item_value, input group_number,
    input element_number, input end_status, output ready
  );
endinterface

`default_nettype wire

>>> design/encrypted_backup_container_parser.sv
// ----------------------------------------------------------------------------
// encrypted_backup_container_parser
// Streaming parser for an encrypted backup container, one byte per word.
// ----------------------------------------------------------------------------
// A byte that yields a result word is taken by the parser, which registers that word.
// Throughput: one byte per cycle while the result register is free or being drained.
// The two-entry queue lets intake continue while a result waits downstream.
// Reset: magic word 0, version and algorithm bytes 1, parser in the magic
// phase with no error latched; no clearing pass.
`default_nettype none

module encrypted_backup_container_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  ebcp_in_if.sink                              in_chan,
  ebcp_out_if.source                           out_chan,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ebcp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ebcp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ebcp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import ebcp_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign in_item.data_byte = in_chan.data_byte;
  assign in_item.last_byte = in_chan.last_byte;

  ebcp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ebcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_chan.valid),
    .push_item_i  (in_item),
    .push_ready_o (in_chan.ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  ebcp_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (q_valid),
    .in_item_i        (q_item),
    .in_ready_o       (q_ready),
    .out_valid_o      (out_chan.valid),
    .out_ready_i      (out_chan.ready),
    .item_kind_o      (out_chan.item_kind),
    .item_value_o     (out_chan.item_value),
    .group_number_o   (out_chan.group_number),
    .element_number_o (out_chan.element_number),
    .end_status_o     (out_chan.end_status)
  );

endmodule

`default_nettype wire

>>> design/ebcp_cfg.sv
// ----------------------------------------------------------------------------
// ebcp_cfg
// APB register file holding the magic word, version and algorithm bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ebcp_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ebcp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ebcp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ebcp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output ebcp_pkg::cfg_t                        cfg_o
);
  import ebcp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:3]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word     <= '0;
      cfg_q.format_version <= 8'd1;
      cfg_q.algorithm_id   <= 8'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAGIC:     cfg_q.magic_word     <= pwdata[47:0];
        REG_VERSION:   cfg_q.format_version <= pwdata[7:0];
        REG_ALGORITHM: cfg_q.algorithm_id   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAGIC:     prdata = {16'd0, cfg_q.magic_word};
      REG_VERSION:   prdata = {56'd0, cfg_q.format_version};
      REG_ALGORITHM: prdata = {56'd0, cfg_q.algorithm_id};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/ebcp_queue.sv
// ----------------------------------------------------------------------------
// ebcp_queue
// Two-entry queue between the byte intake and the parsing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ebcp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  input  wire ebcp_pkg::item_t push_item_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output ebcp_pkg::item_t      pop_item_o,
  input  wire logic            pop_ready_i
);
  import ebcp_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ebcp_parser.sv
// ----------------------------------------------------------------------------
// ebcp_parser
// FSM: one byte per cycle into a registered result word unless output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ebcp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ebcp_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  input  wire ebcp_pkg::item_t in_item_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           item_kind_o,
  output logic [31:0]          item_value_o,
  output logic [7:0]           group_number_o,
  output logic [24:0]          element_number_o,
  output logic [3:0]           end_status_o
);
  import ebcp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_PCOUNT, PH_PLEN, PH_CHILD, PH_SCOUNT, PH_SECRET,
    PH_ALGO, PH_NONCE, PH_LEN0, PH_LENX, PH_CIPHER, PH_DONE, PH_ERROR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [25:0] seen_q, seen_d;
  logic [7:0]  groups_q, groups_d;
  logic [7:0]  elems_q, elems_d;
  logic [7:0]  grp_cnt_q, grp_cnt_d;
  logic [5:0]  biw_q, biw_d;
  logic [63:0] acc_q, acc_d;
  logic [25:0] rem_q, rem_d;
  status_e     err_q, err_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [31:0] value_q, value_d;
  logic [7:0]  grpn_q, grpn_d;
  logic [24:0] elem_q, elem_d;
  status_e     status_q, status_d;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  expect_byte;
  logic [7:0]  pos;
  logic [31:0] word;
  logic [5:0]  biw_inc;
  logic [63:0] len_acc;
  logic [63:0] len_min;
  logic [63:0] len_total;
  logic        start_cipher;
  logic        fail_len;
  logic [25:0] cipher_pos;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign take       = in_valid_i & in_ready_o;
  assign b          = in_item_i.data_byte;
  assign pos        = acc_q[39:32];
  assign word       = {acc_q[23:0], b};
  assign biw_inc    = biw_q + 6'd1;
  assign len_acc    = acc_q | ({56'd0, b} << {biw_q[2:0], 3'b000});
  assign cipher_pos = acc_q[25:0] - rem_q;

  always_comb begin
    unique case (biw_q[2:0])
      3'd0:    expect_byte = cfg_i.magic_word[47:40];
      3'd1:    expect_byte = cfg_i.magic_word[39:32];
      3'd2:    expect_byte = cfg_i.magic_word[31:24];
      3'd3:    expect_byte = cfg_i.magic_word[23:16];
      3'd4:    expect_byte = cfg_i.magic_word[15:8];
      default: expect_byte = cfg_i.magic_word[7:0];
    endcase
  end

  always_comb begin
    priority if (elems_q == 8'd2) begin
      len_min = 64'd253;
    end else if (elems_q == 8'd4) begin
      len_min = 64'h1_0000;
    end else begin
      len_min = 64'h1_0000_0000;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    seen_d    = (seen_q != SEEN_MAX) ? seen_q + 26'd1 : seen_q;
    groups_d  = groups_q;
    elems_d   = elems_q;
    grp_cnt_d = grp_cnt_q;
    biw_d     = biw_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    err_d     = err_q;
    kind_d    = KIND_NONE;
    value_d   = '0;
    grpn_d    = '0;
    elem_d    = '0;
    status_d  = ST_NOT_FINAL;
    start_cipher = 1'b0;
    fail_len     = 1'b0;
    len_total    = {56'd0, b};

    unique case (phase_q)
      PH_MAGIC: begin
        if (b != expect_byte) begin
          err_d   = ST_MAGIC;
          phase_d = PH_ERROR;
        end else if (biw_inc == 6'd6) begin
          biw_d   = '0;
          phase_d = PH_VERSION;
        end else begin
          biw_d = biw_inc;
        end
      end
      PH_VERSION: begin
        if (b != cfg_i.format_version) begin
          err_d   = ST_VERSION;
          phase_d = PH_ERROR;
        end else begin
          kind_d  = KIND_VERSION;
          value_d = {24'd0, b};
          phase_d = PH_PCOUNT;
        end
      end
      PH_PCOUNT: begin
        groups_d  = b;
        grp_cnt_d = '0;
        phase_d   = (b != 8'd0) ? PH_PLEN : PH_SCOUNT;
      end
      PH_PLEN: begin
        if (b == 8'd0) begin
          err_d   = ST_EMPTY_PATH;
          phase_d = PH_ERROR;
        end else begin
          kind_d  = KIND_PATH_LEN;
          value_d = {24'd0, b};
          grpn_d  = grp_cnt_q;
          elems_d = b;
          biw_d   = '0;
          acc_d   = '0;
          phase_d = PH_CHILD;
        end
      end
      PH_CHILD: begin
        // The child position rides in the accumulator above the word.
        if (biw_inc >= CHILD_LEN) begin
          kind_d  = KIND_CHILD;
          value_d = word;
          grpn_d  = grp_cnt_q;
          elem_d  = {17'd0, pos};
          biw_d   = '0;
          acc_d   = {24'd0, pos + 8'd1, 32'd0};
          elems_d = elems_q - 8'd1;
          if (elems_q == 8'd1) begin
            grp_cnt_d = grp_cnt_q + 8'd1;
            groups_d  = groups_q - 8'd1;
            phase_d   = (groups_q != 8'd1) ? PH_PLEN : PH_SCOUNT;
          end
        end else begin
          biw_d = biw_inc;
          acc_d = {24'd0, pos, word};
        end
      end
      PH_SCOUNT: begin
        if (b == 8'd0) begin
          err_d   = ST_NO_SECRETS;
          phase_d = PH_ERROR;
        end else begin
          groups_d  = b;
          grp_cnt_d = '0;
          biw_d     = '0;
          phase_d   = PH_SECRET;
        end
      end
      PH_SECRET: begin
        kind_d  = KIND_SECRET;
        value_d = {24'd0, b};
        grpn_d  = grp_cnt_q;
        elem_d  = {19'd0, biw_q};
        if (biw_inc >= SECRET_LEN) begin
          biw_d     = '0;
          grp_cnt_d = grp_cnt_q + 8'd1;
          groups_d  = groups_q - 8'd1;
          if (groups_q == 8'd1) phase_d = PH_ALGO;
        end else begin
          biw_d = biw_inc;
        end
      end
      PH_ALGO: begin
        if (b != cfg_i.algorithm_id) begin
          err_d   = ST_ALGORITHM;
          phase_d = PH_ERROR;
        end else begin
          kind_d  = KIND_ALGO;
          value_d = {24'd0, b};
          biw_d   = '0;
          phase_d = PH_NONCE;
        end
      end
      PH_NONCE: begin
        kind_d  = KIND_NONCE;
        value_d = {24'd0, b};
        elem_d  = {19'd0, biw_q};
        if (biw_inc >= 6'(NONCE_BYTES)) begin
          biw_d   = '0;
          phase_d = PH_LEN0;
        end else begin
          biw_d = biw_inc;
        end
      end
      PH_LEN0: begin
        if (b < 8'd253) begin
          start_cipher = 1'b1;
        end else begin
          elems_d = (b == 8'd253) ? 8'd2 : (b == 8'd254) ? 8'd4 : 8'd8;
          acc_d   = '0;
          biw_d   = '0;
          phase_d = PH_LENX;
        end
      end
      PH_LENX: begin
        // Length bytes arrive least significant first.
        acc_d = len_acc;
        biw_d = {3'd0, biw_q[2:0]} + 6'd1;
        if ({2'd0, biw_d} >= elems_q) begin
          biw_d     = '0;
          len_total = len_acc;
          if (len_acc < len_min) begin
            fail_len = 1'b1;
          end else begin
            start_cipher = 1'b1;
          end
        end
      end
      PH_CIPHER: begin
        kind_d  = KIND_CIPHER;
        value_d = {24'd0, b};
        elem_d  = cipher_pos[24:0];
        rem_d   = rem_q - 26'd1;
        if (rem_q == 26'd1) phase_d = PH_DONE;
      end
      PH_DONE, PH_ERROR: ;
      default: ;
    endcase

    if (start_cipher) begin
      if (len_total > MAX_CIPHER_BYTES) begin
        fail_len = 1'b1;
      end else if (len_total == 64'd0) begin
        phase_d = PH_DONE;
      end else begin
        acc_d   = len_total;
        rem_d   = len_total[25:0];
        phase_d = PH_CIPHER;
      end
    end
    if (fail_len) begin
      err_d   = ST_BAD_LENGTH;
      phase_d = PH_ERROR;
    end

    if (in_item_i.last_byte) begin
      priority if (seen_d < MIN_TOTAL) begin
        status_d = ST_TOO_SHORT;
      end else if (err_q != ST_NOT_FINAL) begin
        status_d = err_q;
      end else if (phase_d == PH_DONE) begin
        status_d = ST_OK;
      end else if (err_d != ST_NOT_FINAL) begin
        status_d = err_d;
      end else begin
        status_d = ST_TRUNCATED;
      end
      phase_d   = PH_MAGIC;
      seen_d    = '0;
      groups_d  = '0;
      elems_d   = '0;
      grp_cnt_d = '0;
      biw_d     = '0;
      acc_d     = '0;
      rem_d     = '0;
      err_d     = ST_NOT_FINAL;
    end

    out_valid_d = out_valid_q & ~out_ready_i;
    if (take) begin
      out_valid_d = (kind_d != KIND_NONE) | in_item_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      seen_q      <= '0;
      groups_q    <= '0;
      elems_q     <= '0;
      grp_cnt_q   <= '0;
      biw_q       <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      err_q       <= ST_NOT_FINAL;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q   <= phase_d;
        seen_q    <= seen_d;
        groups_q  <= groups_d;
        elems_q   <= elems_d;
        grp_cnt_q <= grp_cnt_d;
        biw_q     <= biw_d;
        acc_q     <= acc_d;
        rem_q     <= rem_d;
        err_q     <= err_d;
      end
    end
  end

  // Result word; no reset needed.
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      grpn_q   <= grpn_d;
      elem_q   <= elem_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign item_value_o     = value_q;
  assign group_number_o   = grpn_q;
  assign element_number_o = elem_q;
  assign end_status_o     = status_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the backup container parser. Whole containers, cut
// ones, corrupted ones and plain noise are streamed into the byte channel,
// under several register settings and idle mixes. Every accepted byte is
// decoded by an in-bench parser, and each result word is compared with it.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ebcp_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 60;
  localparam int NUM_PHASES     = 6;

  // CompactSize prefixes that announce a 2 or 4 byte length; a higher prefix announces 8.
  localparam logic [7:0] LEN_PREFIX16 = 8'd253;
  localparam logic [7:0] LEN_PREFIX32 = 8'd254;

  typedef enum logic [3:0] {
    PS_MAGIC, PS_VERSION, PS_PCOUNT, PS_PLEN, PS_CHILD, PS_SCOUNT, PS_SECRET,
    PS_ALGO, PS_NONCE, PS_LEN0, PS_LENX, PS_CIPHER, PS_DONE, PS_ERROR
  } parse_phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [7:0]  grp_no;
    logic [24:0] elem;
    status_e     status;
  } elem_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ebcp_in_if  in_if ();
  ebcp_out_if out_if ();

  encrypted_backup_container_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register copies, starting from their reset values.
  logic [47:0] cfg_magic   = '0;
  logic [7:0]  cfg_version = 8'd1;
  logic [7:0]  cfg_algo    = 8'd1;

  // Parser state of the prediction.
  parse_phase_e p_phase       = PS_MAGIC;
  logic [25:0]  p_count       = '0;
  logic [7:0]   p_groups      = '0;
  logic [7:0]   p_elems       = '0;
  logic [7:0]   p_group_no    = '0;
  logic [5:0]   p_pos         = '0;
  logic [63:0]  p_acc         = '0;
  logic [25:0]  p_cipher_left = '0;
  status_e      p_err         = ST_NOT_FINAL;

  item_t     pending_bytes[$];
  elem_rec_t expected_elems[$];
  logic [7:0] frame[$];
  int scount_pos;
  int algo_pos;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int containers_queued = 0;
  int settings_used = 1;
  int results_checked = 0;
  int fail_count = 0;
  int stall_cycles = 0;
  int end_count[10] = '{default: 0};

  function automatic void add_byte(input logic [7:0] v);
    frame.insert(frame.size(), v);
  endfunction

  function automatic void fail(input status_e code);
    p_err   = code;
    p_phase = PS_ERROR;
  endfunction

  function automatic void open_ciphertext(input logic [63:0] n);
    if (n > MAX_CIPHER_BYTES) begin
      fail(ST_BAD_LENGTH);
    end else if (n == 0) begin
      p_phase = PS_DONE;
    end else begin
      p_acc         = n;
      p_cipher_left = n[25:0];
      p_phase       = PS_CIPHER;
    end
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a word.
  function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
                                     output elem_rec_t r);
    logic [7:0]  idx8;
    logic [31:0] w;
    logic [63:0] floor_val;
    logic [2:0]  k;
    r = '0;
    if (p_count < SEEN_MAX) p_count = p_count + 1'b1;
    case (p_phase)
      PS_MAGIC: begin
        if (b != cfg_magic[8 * (5 - int'(p_pos)) +: 8]) begin
          fail(ST_MAGIC);
        end else if (p_pos == 6'd5) begin
          p_pos   = '0;
          p_phase = PS_VERSION;
        end else begin
          p_pos = p_pos + 1'b1;
        end
      end
      PS_VERSION: begin
        if (b != cfg_version) begin
          fail(ST_VERSION);
        end else begin
          r.kind  = KIND_VERSION;
          r.value = {24'd0, b};
          p_phase = PS_PCOUNT;
        end
      end
      PS_PCOUNT: begin
        p_groups   = b;
        p_group_no = '0;
        p_phase    = (b != 0) ? PS_PLEN : PS_SCOUNT;
      end
      PS_PLEN: begin
        if (b == 0) begin
          fail(ST_EMPTY_PATH);
        end else begin
          r.kind   = KIND_PATH_LEN;
          r.value  = {24'd0, b};
          r.grp_no = p_group_no;
          p_elems  = b;
          p_pos    = '0;
          p_acc    = '0;
          p_phase  = PS_CHILD;
        end
      end
      PS_CHILD: begin
        // Bits 39:32 of the accumulator hold the index of the child in its path.
        idx8  = p_acc[39:32];
        w     = {p_acc[23:0], b};
        p_pos = p_pos + 1'b1;
        if (p_pos >= CHILD_LEN) begin
          r.kind   = KIND_CHILD;
          r.value  = w;
          r.grp_no = p_group_no;
          r.elem   = {17'd0, idx8};
          p_pos    = '0;
          p_acc    = {24'd0, idx8 + 8'd1, 32'd0};
          p_elems  = p_elems - 1'b1;
          if (p_elems == 0) begin
            p_group_no = p_group_no + 1'b1;
            p_groups   = p_groups - 1'b1;
            p_phase    = (p_groups != 0) ? PS_PLEN : PS_SCOUNT;
          end
        end else begin
          p_acc = {24'd0, idx8, w};
        end
      end
      PS_SCOUNT: begin
        if (b == 0) begin
          fail(ST_NO_SECRETS);
        end else begin
          p_groups   = b;
          p_group_no = '0;
          p_pos      = '0;
          p_phase    = PS_SECRET;
        end
      end
      PS_SECRET: begin
        r.kind   = KIND_SECRET;
        r.value  = {24'd0, b};
        r.grp_no = p_group_no;
        r.elem   = {19'd0, p_pos};
        p_pos    = p_pos + 1'b1;
        if (p_pos >= SECRET_LEN) begin
          p_pos      = '0;
          p_group_no = p_group_no + 1'b1;
          p_groups   = p_groups - 1'b1;
          if (p_groups == 0) p_phase = PS_ALGO;
        end
      end
      PS_ALGO: begin
        if (b != cfg_algo) begin
          fail(ST_ALGORITHM);
        end else begin
          r.kind  = KIND_ALGO;
          r.value = {24'd0, b};
          p_pos   = '0;
          p_phase = PS_NONCE;
        end
      end
      PS_NONCE: begin
        r.kind  = KIND_NONCE;
        r.value = {24'd0, b};
        r.elem  = {19'd0, p_pos};
        p_pos   = p_pos + 1'b1;
        if (p_pos >= NONCE_BYTES) begin
          p_pos   = '0;
          p_phase = PS_LEN0;
        end
      end
      PS_LEN0: begin
        if (b < LEN_PREFIX16) begin
          open_ciphertext({56'd0, b});
        end else begin
          p_elems = (b == LEN_PREFIX16) ? 8'd2 : (b == LEN_PREFIX32) ? 8'd4 : 8'd8;
          p_acc   = '0;
          p_pos   = '0;
          p_phase = PS_LENX;
        end
      end
      PS_LENX: begin
        // Length bytes arrive least significant first.
        k     = p_pos[2:0];
        p_acc = p_acc | ({56'd0, b} << (8 * int'(k)));
        p_pos = {3'd0, k} + 6'd1;
        if (p_pos >= p_elems[5:0]) begin
          floor_val = (p_elems == 8'd2) ? 64'd253 :
                      (p_elems == 8'd4) ? 64'h1_0000 : 64'h1_0000_0000;
          p_pos = '0;
          if (p_acc < floor_val) fail(ST_BAD_LENGTH);
          else open_ciphertext(p_acc);
        end
      end
      PS_CIPHER: begin
        r.kind        = KIND_CIPHER;
        r.value       = {24'd0, b};
        r.elem        = 25'(p_acc - {38'd0, p_cipher_left});
        p_cipher_left = p_cipher_left - 1'b1;
        if (p_cipher_left == 0) p_phase = PS_DONE;
      end
      default: ;
    endcase

    if (is_last) begin
      if (p_count < MIN_TOTAL) r.status = ST_TOO_SHORT;
      else if (p_err != ST_NOT_FINAL) r.status = p_err;
      else if (p_phase == PS_DONE) r.status = ST_OK;
      else r.status = ST_TRUNCATED;
      p_phase       = PS_MAGIC;
      p_count       = '0;
      p_groups      = '0;
      p_elems       = '0;
      p_group_no    = '0;
      p_pos         = '0;
      p_acc         = '0;
      p_cipher_left = '0;
      p_err         = ST_NOT_FINAL;
    end
    return (r.kind != KIND_NONE) || is_last;
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Builds a container for the current register settings.
  function automatic void build_frame(input int n_paths, input int plen_lo,
                                      input int plen_hi, input int n_sec,
                                      input int len_form, input logic [63:0] len_decl,
                                      input int body_len);
    int n_child;
    int n_len;
    frame.delete();
    for (int i = 0; i < 6; i++) add_byte(cfg_magic[8 * (5 - i) +: 8]);
    add_byte(cfg_version);
    add_byte(8'(n_paths));
    for (int p = 0; p < n_paths; p++) begin
      n_child = $urandom_range(plen_hi, plen_lo);
      add_byte(8'(n_child));
      repeat (4 * n_child) add_byte(rand_byte());
    end
    scount_pos = frame.size();
    add_byte(8'(n_sec));
    repeat (int'(SECRET_LEN) * n_sec) add_byte(rand_byte());
    algo_pos = frame.size();
    add_byte(cfg_algo);
    repeat (NONCE_BYTES) add_byte(rand_byte());
    case (len_form)
      0: n_len = 0;
      1: n_len = 2;
      2: n_len = 4;
      default: n_len = 8;
    endcase
    if (n_len == 0) add_byte(len_decl[7:0]);
    else add_byte(LEN_PREFIX16 + 8'(len_form - 1));
    for (int i = 0; i < n_len; i++) add_byte(len_decl[8 * i +: 8]);
    repeat (body_len) add_byte(rand_byte());
  endfunction

  // Queues the frame, cut to keep bytes when keep is nonzero, last flag on
  // its final byte.
  function automatic void queue_frame(input int keep);
    item_t it;
    if (keep > 0) while (frame.size() > keep) frame.delete(frame.size() - 1);
    foreach (frame[i]) begin
      it.data_byte = frame[i];
      it.last_byte = (i == frame.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    bytes_queued += frame.size();
    containers_queued++;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (bytes_accepted != bytes_queued || expected_elems.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAGIC:     cfg_magic   = value[47:0];
      REG_VERSION:   cfg_version = value[7:0];
      REG_ALGORITHM: cfg_algo    = value[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : byte_driver
    item_t     nxt;
    elem_rec_t rec;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= '0;
      in_if.last_byte <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (decode_byte(in_if.data_byte, in_if.last_byte, rec)) begin
          expected_elems.insert(expected_elems.size(), rec);
        end
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_if.valid     <= 1'b1;
          in_if.data_byte <= nxt.data_byte;
          in_if.last_byte <= nxt.last_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : word_monitor
    elem_rec_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        if (out_if.end_status < 4'd10) end_count[out_if.end_status]++;
        if (expected_elems.size() == 0) begin
          $error("unexpected result word: item_kind %0d, end_status %0d",
                 out_if.item_kind, out_if.end_status);
          fail_count++;
        end else begin
          want = expected_elems.pop_front();
          check_field("item_kind", want.kind, out_if.item_kind);
          check_field("item_value", want.value, out_if.item_value);
          check_field("group_number", want.grp_no, out_if.group_number);
          check_field("element_number", want.elem, out_if.element_number);
          check_field("end_status", want.status, out_if.end_status);
        end
      end
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          n_paths;
    int          n_sec;
    int          form;
    int          body;
    int          pick;
    int          phase_start;
    logic [63:0] len;
    logic [47:0] magic;
    logic [7:0]  ver;
    logic [7:0]  alg;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed containers, checked against the reset register values.
    tx_idle_pct = 13;
    rx_idle_pct = 53;
    build_frame(0, 1, 1, 1, 0, 64'd0, 0);           // no paths, empty ciphertext
    queue_frame(0);
    build_frame(2, 1, 2, 1, 0, 64'd3, 3);           // complete, then trailing bytes
    repeat (3) add_byte(rand_byte());
    queue_frame(0);
    frame.delete();                                 // lone final byte
    add_byte(8'hA5);
    queue_frame(0);
    build_frame(0, 1, 1, 1, 0, 64'd0, 0);
    frame[2] ^= 8'h40;
    queue_frame(30);                                // magic mismatch, rest ignored
    build_frame(0, 1, 1, 1, 0, 64'd0, 0);
    frame[4] ^= 8'h01;
    queue_frame(10);                                // too short wins over the error
    build_frame(0, 1, 1, 1, 0, 64'd0, 0);
    frame[6] ^= 8'h01;
    queue_frame(0);
    build_frame(1, 1, 1, 1, 0, 64'd0, 0);
    frame[8] = 8'h00;                               // path with no children
    queue_frame(0);
    build_frame(0, 1, 1, 1, 0, 64'd0, 0);
    frame[scount_pos] = 8'h00;
    queue_frame(0);
    build_frame(1, 1, 1, 1, 0, 64'd0, 0);
    frame[algo_pos] ^= 8'h80;
    queue_frame(0);
    build_frame(0, 1, 1, 1, 1, 64'd100, 4);         // non-minimal lengths
    queue_frame(0);
    build_frame(0, 1, 1, 1, 2, 64'd300, 4);
    queue_frame(0);
    build_frame(0, 1, 1, 1, 3, 64'd5, 2);
    queue_frame(0);
    build_frame(0, 1, 1, 1, 3, 64'h1_0000_0000, 2);
    queue_frame(0);
    build_frame(0, 1, 1, 1, 2, 64'h200_0001, 3);    // one past the length limit
    queue_frame(0);
    build_frame(0, 1, 1, 1, 2, 64'h200_0000, 5);    // at the limit, then cut
    queue_frame(0);
    build_frame(0, 1, 1, 1, 1, 64'd253, 6);         // smallest two-byte length, cut
    queue_frame(0);
    build_frame(1, 1, 2, 2, 0, 64'd5, 5);
    queue_frame(40);                                // cut inside a secret
    build_frame(8, 1, 1, 1, 0, 64'd1, 1);
    queue_frame(0);
    build_frame(1, 20, 20, 1, 0, 64'd0, 0);
    queue_frame(0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      tx_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 53 : 0;
      rx_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 13 : 0;
      case (ph)
        0: begin
          magic = 48'hFFFF_FFFF_FFFF;
          ver   = 8'hFF;
          alg   = 8'h00;
        end
        2: begin
          magic = '0;
          ver   = 8'h00;
          alg   = 8'hFF;
        end
        default: begin
          magic = 48'({$urandom, $urandom});
          ver   = 8'($urandom);
          alg   = 8'($urandom);
        end
      endcase
      write_reg(REG_MAGIC, {16'd0, magic});
      write_reg(REG_VERSION, {56'd0, ver});
      write_reg(REG_ALGORITHM, {56'd0, alg});
      settings_used++;

      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        n_paths = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(3, 1));
        n_sec   = $urandom_range(2, 1);
        form    = 0;
        len     = 64'($urandom_range(12));
        pick    = $urandom_range(99);
        if (pick < 6) begin
          len = 64'($urandom_range(252, 200));
        end else if (pick >= 84 && pick < 92) begin
          form = 1;
          len  = 64'($urandom_range(260, 253));
        end else if (pick >= 92 && pick < 95) begin
          form = 1;
          len  = 64'($urandom_range(252));
        end else if (pick >= 95 && pick < 98) begin
          form = 2;
          len  = 64'($urandom_range(70000, 65536));
        end else if (pick >= 98) begin
          form = 3;
          len  = {$urandom, $urandom};
        end
        body = (len > 300) ? 6 : int'(len);
        build_frame(n_paths, 1, 3, n_sec, form, len, body);

        pick = $urandom_range(99);
        if (pick < 20) begin
          queue_frame($urandom_range(frame.size(), 1));
        end else if (pick < 36) begin
          frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
          queue_frame(0);
        end else if (pick < 44) begin
          frame.delete();
          repeat ($urandom_range(30, 1)) add_byte(rand_byte());
          queue_frame(0);
        end else begin
          if ($urandom_range(3) == 0) repeat ($urandom_range(4, 1)) add_byte(rand_byte());
          queue_frame(0);
        end

        // Now and then the sender holds off until the parser has drained.
        if ($urandom_range(11) == 0) wait_idle();
      end
    end

    wait_idle();
    $display("Run covered %0d bytes in %0d containers under %0d register settings;",
             bytes_accepted, containers_queued, settings_used);
    $display("%0d words checked. Endings: ok %0d, magic %0d, version %0d, truncated %0d,",
             results_checked, end_count[1], end_count[2], end_count[3], end_count[4]);
    $display("empty path %0d, no secrets %0d, algorithm %0d, bad length %0d, too short %0d.",
             end_count[5], end_count[6], end_count[7], end_count[8], end_count[9]);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
